### hdl/variable_record_stack_core_macros.svh
// ----------------------------------------------------------------------------
// variable_record_stack_core_macros.svh
// Assertion macros shared by the checker of the record stack core.
// ----------------------------------------------------------------------------
`ifndef VARIABLE_RECORD_STACK_CORE_MACROS_SVH
`define VARIABLE_RECORD_STACK_CORE_MACROS_SVH

// same-cycle implication, held off while reset is asserted
`define VRS_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vrs assertion failed");

// next-cycle implication, held off while reset is asserted
`define VRS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vrs assertion failed");

`endif

### hdl/vrs_pkg.sv
// ----------------------------------------------------------------------------
// vrs_pkg
// Constants, codes and types of the variable-length record stack.
// ----------------------------------------------------------------------------
`default_nettype none

package vrs_pkg;

    // storage sizing
    localparam int CAPACITY   = 1024;
    localparam int MAX_RECORD = 64;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int PTR_W      = $clog2(CAPACITY + 1);
    localparam int SUM_W      = PTR_W + 1;
    localparam int LEN_W      = $clog2(MAX_RECORD + 1);

    // field widths
    localparam int DATA_W   = 8;
    localparam int OP_W     = 2;
    localparam int REQ_W    = 7;
    localparam int STATUS_W = 2;
    localparam int CMP_W    = (PTR_W > DATA_W) ? PTR_W : DATA_W;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // operation codes on the command channel
    localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
    localparam logic [OP_W-1:0] OP_POP   = 2'd1;
    localparam logic [OP_W-1:0] OP_PEEK  = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

    // status codes on the response channel
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_CLEARED = 2'd3;

    // classified command kinds
    localparam int KIND_W = 3;
    localparam logic [KIND_W-1:0] KIND_PUSH      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_LAST = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP       = 3'd2;
    localparam logic [KIND_W-1:0] KIND_PEEK      = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR     = 3'd4;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [DATA_W-1:0] data_byte;
        logic [REQ_W-1:0]  max_len;
    } cmd_t;

    typedef struct packed {
        logic [DATA_W-1:0]   out_byte;
        logic                has_byte;
        logic                end_of_run;
        logic [STATUS_W-1:0] status;
        logic                is_empty;
    } rsp_t;

endpackage

`default_nettype wire

### hdl/vrs_if.sv
// ----------------------------------------------------------------------------
// vrs_if
// Command and response channel interfaces of the record stack.
// ----------------------------------------------------------------------------
`default_nettype none

interface vrs_cmd_if;
    import vrs_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] data_byte;
    logic              last;
    logic [REQ_W-1:0]  max_len;

    modport source (output valid, output op, output data_byte, output last,
                    output max_len, input ready);
    modport sink   (input valid, input op, input data_byte, input last,
                    input max_len, output ready);
endinterface

interface vrs_rsp_if;
    import vrs_pkg::*;

    logic                valid;
    logic                ready;
    logic [DATA_W-1:0]   out_byte;
    logic                has_byte;
    logic                end_of_run;
    logic [STATUS_W-1:0] status;
    logic                is_empty;

    modport source (output valid, output out_byte, output has_byte,
                    output end_of_run, output status, output is_empty,
                    input ready);
    modport sink   (input valid, input out_byte, input has_byte,
                    input end_of_run, input status, input is_empty,
                    output ready);
endinterface

`default_nettype wire

### hdl/vrs_front.sv
// ----------------------------------------------------------------------------
// vrs_front
// Accepts command transactions and classifies them into command kinds
// for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module vrs_front (
    vrs_cmd_if.sink       cmd,
    output logic          q_valid,
    input  logic          q_ready,
    output vrs_pkg::cmd_t q_cmd
);
    import vrs_pkg::*;

    logic [KIND_W-1:0] kind;

    // classify the operation; the last flag splits pushes in two kinds
    always_comb
    begin
        case (cmd.op)
            OP_PUSH:  kind = cmd.last ? KIND_PUSH_LAST : KIND_PUSH;
            OP_POP:   kind = KIND_POP;
            OP_PEEK:  kind = KIND_PEEK;
            OP_CLEAR: kind = KIND_CLEAR;
            default:  kind = KIND_CLEAR;
        endcase
    end

    // a transaction is taken whenever the queue has room
    assign q_valid         = cmd.valid;
    assign cmd.ready       = q_ready;
    assign q_cmd.kind      = kind;
    assign q_cmd.data_byte = cmd.data_byte;
    assign q_cmd.max_len   = cmd.max_len;

endmodule

`default_nettype wire

### hdl/vrs_queue.sv
// ----------------------------------------------------------------------------
// vrs_queue
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
`default_nettype none

module vrs_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  vrs_pkg::cmd_t wr_data,
    output logic          rd_valid,
    input  logic          rd_ready,
    output vrs_pkg::cmd_t rd_data
);
    import vrs_pkg::*;

    cmd_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg;
    logic [QUEUE_AW:0]   count_next;
    logic                do_wr;
    logic                do_rd;

    assign wr_ready = (count_reg != (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + QUEUE_AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + QUEUE_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + (QUEUE_AW + 1)'(1);
        end
        else if (!do_wr && do_rd)
        begin
            count_next = count_reg - (QUEUE_AW + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

### hdl/vrs_back.sv
// ----------------------------------------------------------------------------
// vrs_back
// Executes queued commands against the byte store and stack pointers,
// and buffers responses in a two-entry output buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module vrs_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    output logic          q_ready,
    input  vrs_pkg::cmd_t q_cmd,
    vrs_rsp_if.source     rsp
);
    import vrs_pkg::*;

    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_TRAILER = 2'd1;
    localparam logic [1:0] S_LEN     = 2'd2;
    localparam logic [1:0] S_EMIT    = 2'd3;

    // sequencer state
    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [PTR_W-1:0]  top_reg;
    logic [PTR_W-1:0]  top_next;
    logic [LEN_W-1:0]  plen_reg;
    logic [LEN_W-1:0]  plen_next;
    logic              povf_reg;
    logic              povf_next;
    logic [ADDR_W-1:0] trl_addr_reg;
    logic [ADDR_W-1:0] trl_addr_next;
    logic [LEN_W-1:0]  trl_val_reg;
    logic [LEN_W-1:0]  trl_val_next;
    logic [REQ_W-1:0]  req_reg;
    logic [REQ_W-1:0]  req_next;
    logic              is_pop_reg;
    logic              is_pop_next;
    logic [ADDR_W-1:0] rd_addr_reg;
    logic [ADDR_W-1:0] rd_addr_next;
    logic [LEN_W-1:0]  remain_reg;
    logic [LEN_W-1:0]  remain_next;

    // byte store
    logic [DATA_W-1:0] store_mem [CAPACITY];
    logic [DATA_W-1:0] rd_data_reg;
    logic              mem_wr_en;
    logic [ADDR_W-1:0] mem_wr_addr;
    logic [DATA_W-1:0] mem_wr_data;
    logic              mem_rd_en;
    logic [ADDR_W-1:0] mem_rd_addr;

    // response stage and output buffer
    logic              issue;
    rsp_t              iss_res;
    logic              stg_valid_reg;
    rsp_t              stg_res_reg;
    rsp_t              res_mem_reg [2];
    logic              res_wr_reg;
    logic              res_rd_reg;
    logic [1:0]        res_cnt_reg;
    logic [1:0]        res_cnt_next;
    logic              res_deq;
    logic              issue_ok;
    rsp_t              res_head;
    rsp_t              res_fill;

    // push arithmetic
    logic [SUM_W-1:0]  pos_w;
    logic              fit;

    // pop and peek arithmetic
    logic [PTR_W-1:0]  trail_w;
    logic [CMP_W-1:0]  rd_ext;
    logic [CMP_W-1:0]  trail_ext;
    logic [CMP_W-1:0]  req_ext;
    logic [CMP_W-1:0]  len_w;
    logic [CMP_W-1:0]  n1_w;
    logic [CMP_W-1:0]  n_w;
    logic [LEN_W-1:0]  n_len;
    logic [ADDR_W-1:0] start_addr;
    logic [PTR_W-1:0]  new_top;
    logic [PTR_W-1:0]  top_after;

    // room in the output buffer for one more response, counting the staged one
    assign res_deq  = rsp.valid && rsp.ready;
    assign issue_ok = (({1'b0, res_cnt_reg} + {2'b00, stg_valid_reg})
                       - {2'b00, res_deq}) <= 3'd1;

    // next byte position and whether it still fits
    assign pos_w = {1'b0, top_reg} + SUM_W'(plen_reg);
    assign fit   = !povf_reg && (plen_reg < LEN_W'(MAX_RECORD))
                   && ((pos_w + SUM_W'(1)) < SUM_W'(CAPACITY));

    // clipped record length and request from the trailer byte
    assign trail_w    = top_reg - PTR_W'(1);
    assign rd_ext     = CMP_W'(rd_data_reg);
    assign trail_ext  = CMP_W'(trail_w);
    assign req_ext    = CMP_W'(req_reg);
    assign len_w      = (rd_ext > trail_ext) ? trail_ext : rd_ext;
    assign n1_w       = (req_ext < len_w) ? req_ext : len_w;
    assign n_w        = (n1_w > CMP_W'(MAX_RECORD)) ? CMP_W'(MAX_RECORD) : n1_w;
    assign n_len      = LEN_W'(n_w);
    assign start_addr = trail_w[ADDR_W-1:0] - ADDR_W'(n_len);
    assign new_top    = trail_w - PTR_W'(len_w);
    assign top_after  = is_pop_reg ? new_top : top_reg;

    // command sequencer
    always_comb
    begin
        state_next    = state_reg;
        top_next      = top_reg;
        plen_next     = plen_reg;
        povf_next     = povf_reg;
        trl_addr_next = trl_addr_reg;
        trl_val_next  = trl_val_reg;
        req_next      = req_reg;
        is_pop_next   = is_pop_reg;
        rd_addr_next  = rd_addr_reg;
        remain_next   = remain_reg;
        q_ready       = 1'b0;
        mem_wr_en     = 1'b0;
        mem_wr_addr   = '0;
        mem_wr_data   = '0;
        mem_rd_en     = 1'b0;
        mem_rd_addr   = '0;
        issue         = 1'b0;
        iss_res       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid && issue_ok)
                begin
                    q_ready = 1'b1;
                    case (q_cmd.kind)
                        KIND_PUSH, KIND_PUSH_LAST:
                        begin
                            if (fit)
                            begin
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = pos_w[ADDR_W-1:0];
                                mem_wr_data = q_cmd.data_byte;
                            end
                            if (q_cmd.kind == KIND_PUSH)
                            begin
                                if (fit)
                                begin
                                    plen_next = plen_reg + LEN_W'(1);
                                end
                                else
                                begin
                                    povf_next = 1'b1;
                                end
                                issue               = 1'b1;
                                iss_res.end_of_run  = 1'b1;
                                iss_res.status      = ST_OK;
                                iss_res.is_empty    = (top_reg == '0);
                            end
                            else
                            begin
                                plen_next = '0;
                                povf_next = 1'b0;
                                if (fit)
                                begin
                                    // trailer goes in from S_TRAILER once the output buffer has room
                                    trl_addr_next = pos_w[ADDR_W-1:0] + ADDR_W'(1);
                                    trl_val_next  = plen_reg + LEN_W'(1);
                                    state_next    = S_TRAILER;
                                end
                                else
                                begin
                                    issue              = 1'b1;
                                    iss_res.end_of_run = 1'b1;
                                    iss_res.status     = ST_FULL;
                                    iss_res.is_empty   = (top_reg == '0);
                                end
                            end
                        end
                        KIND_CLEAR:
                        begin
                            top_next           = '0;
                            plen_next          = '0;
                            povf_next          = 1'b0;
                            issue              = 1'b1;
                            iss_res.end_of_run = 1'b1;
                            iss_res.status     = ST_CLEARED;
                            iss_res.is_empty   = 1'b1;
                        end
                        KIND_POP, KIND_PEEK:
                        begin
                            if (q_cmd.kind == KIND_POP)
                            begin
                                plen_next = '0;
                                povf_next = 1'b0;
                            end
                            if (top_reg == '0)
                            begin
                                issue              = 1'b1;
                                iss_res.end_of_run = 1'b1;
                                iss_res.status     = ST_EMPTY;
                                iss_res.is_empty   = 1'b1;
                            end
                            else
                            begin
                                // fetch the length trailer of the top record
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = trail_w[ADDR_W-1:0];
                                req_next    = q_cmd.max_len;
                                is_pop_next = (q_cmd.kind == KIND_POP);
                                state_next  = S_LEN;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_TRAILER:
            begin
                if (issue_ok)
                begin
                    mem_wr_en          = 1'b1;
                    mem_wr_addr        = trl_addr_reg;
                    mem_wr_data        = DATA_W'(trl_val_reg);
                    top_next           = PTR_W'(trl_addr_reg) + PTR_W'(1);
                    issue              = 1'b1;
                    iss_res.end_of_run = 1'b1;
                    iss_res.status     = ST_OK;
                    iss_res.is_empty   = 1'b0;
                    state_next         = S_IDLE;
                end
            end
            S_LEN:
            begin
                if (n_len == '0)
                begin
                    // nothing to deliver: one empty-handed response
                    if (issue_ok)
                    begin
                        top_next           = top_after;
                        issue              = 1'b1;
                        iss_res.end_of_run = 1'b1;
                        iss_res.status     = ST_OK;
                        iss_res.is_empty   = (top_after == '0);
                        state_next         = S_IDLE;
                    end
                end
                else
                begin
                    top_next     = top_after;
                    rd_addr_next = start_addr;
                    remain_next  = n_len;
                    state_next   = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (issue_ok)
                begin
                    mem_rd_en          = 1'b1;
                    mem_rd_addr        = rd_addr_reg;
                    rd_addr_next       = rd_addr_reg + ADDR_W'(1);
                    remain_next        = remain_reg - LEN_W'(1);
                    issue              = 1'b1;
                    iss_res.has_byte   = 1'b1;
                    iss_res.end_of_run = (remain_reg == LEN_W'(1));
                    iss_res.status     = ST_OK;
                    iss_res.is_empty   = (top_reg == '0);
                    if (remain_reg == LEN_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            top_reg    <= '0;
            plen_reg   <= '0;
            povf_reg   <= 1'b0;
            remain_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            top_reg    <= top_next;
            plen_reg   <= plen_next;
            povf_reg   <= povf_next;
            remain_reg <= remain_next;
        end
    end

    // command payload registers
    always_ff @(posedge clk)
    begin
        trl_addr_reg <= trl_addr_next;
        trl_val_reg  <= trl_val_next;
        req_reg      <= req_next;
        is_pop_reg   <= is_pop_next;
        rd_addr_reg  <= rd_addr_next;
    end

    // byte store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            store_mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en)
        begin
            rd_data_reg <= store_mem[mem_rd_addr];
        end
    end

    // response stage lines up with the registered read data
    always_comb
    begin
        res_fill          = stg_res_reg;
        res_fill.out_byte = stg_res_reg.has_byte ? rd_data_reg : '0;
    end

    always_comb
    begin
        res_cnt_next = res_cnt_reg;
        if (stg_valid_reg && !res_deq)
        begin
            res_cnt_next = res_cnt_reg + 2'd1;
        end
        else if (!stg_valid_reg && res_deq)
        begin
            res_cnt_next = res_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
            res_wr_reg    <= 1'b0;
            res_rd_reg    <= 1'b0;
            res_cnt_reg   <= '0;
        end
        else
        begin
            stg_valid_reg <= issue;
            res_cnt_reg   <= res_cnt_next;
            if (stg_valid_reg)
            begin
                res_wr_reg <= !res_wr_reg;
            end
            if (res_deq)
            begin
                res_rd_reg <= !res_rd_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        stg_res_reg <= iss_res;
        if (stg_valid_reg)
        begin
            res_mem_reg[res_wr_reg] <= res_fill;
        end
    end

    // output channel
    assign res_head       = res_mem_reg[res_rd_reg];
    assign rsp.valid      = (res_cnt_reg != '0);
    assign rsp.out_byte   = res_head.out_byte;
    assign rsp.has_byte   = res_head.has_byte;
    assign rsp.end_of_run = res_head.end_of_run;
    assign rsp.status     = res_head.status;
    assign rsp.is_empty   = res_head.is_empty;

endmodule

`default_nettype wire

### hdl/variable_record_stack_core.sv
// ----------------------------------------------------------------------------
// variable_record_stack_core
// LIFO stack of variable-length byte records with a length trailer per
// record, kept in a 1024-byte store.
//
//  Channel | Role | Transaction carries
//  --------+------+------------------------------------------------------
//  cmd     | sink | op, data_byte, last, max_len
//  rsp     | src  | out_byte, has_byte, end_of_run, status, is_empty
//
// A push byte, clear, or empty pop/peek is handled in the idle state of the
// back end; the last byte of a record that fits is written, then its trailer.
// Pop and peek do one trailer read and one length step, then deliver one byte
// per cycle from the single store read port while the output buffer has room.
// A four-entry command queue lets cmd keep flowing while the back end works.
// Reset empties the stack at once; stalls on rsp hold the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module variable_record_stack_core (
    input  logic      clk,
    input  logic      rst_n,
    vrs_cmd_if.sink   cmd,
    vrs_rsp_if.source rsp
);
    import vrs_pkg::*;

    logic fq_valid;
    logic fq_ready;
    cmd_t fq_cmd;
    logic qb_valid;
    logic qb_ready;
    cmd_t qb_cmd;

    vrs_front u_front (
        .cmd     (cmd),
        .q_valid (fq_valid),
        .q_ready (fq_ready),
        .q_cmd   (fq_cmd)
    );

    vrs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  (fq_cmd),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_data  (qb_cmd)
    );

    vrs_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (qb_valid),
        .q_ready (qb_ready),
        .q_cmd   (qb_cmd),
        .rsp     (rsp)
    );

endmodule

`default_nettype wire

### hdl/vrs_checker.sv
// ----------------------------------------------------------------------------
// vrs_checker
// Port-level checks on the response channel of the record stack core.
// ----------------------------------------------------------------------------
`default_nettype none

`include "variable_record_stack_core_macros.svh"

module vrs_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [vrs_pkg::DATA_W-1:0]    rsp_out_byte,
    input logic                          rsp_has_byte,
    input logic                          rsp_end_of_run,
    input logic [vrs_pkg::STATUS_W-1:0]  rsp_status,
    input logic                          rsp_is_empty
);
    import vrs_pkg::*;

    // a stalled response transaction holds its payload
    `VRS_ASSERT_NEXT(a_stall_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_byte) && $stable(rsp_status) && $stable(rsp_end_of_run))

    // nothing is pending right after reset is released
    `VRS_ASSERT_NOW(a_quiet_after_reset, clk, rst_n, $rose(rst_n), !rsp_valid)

    // data bytes only come with ok status
    `VRS_ASSERT_NOW(a_byte_ok, clk, rst_n, rsp_valid && rsp_has_byte, rsp_status == ST_OK)

    // an empty report is a single byteless response on an empty stack
    `VRS_ASSERT_NOW(a_empty_report, clk, rst_n, rsp_valid && (rsp_status == ST_EMPTY), rsp_is_empty && !rsp_has_byte && rsp_end_of_run)

    // a clear leaves the stack empty
    `VRS_ASSERT_NOW(a_clear_empty, clk, rst_n, rsp_valid && (rsp_status == ST_CLEARED), rsp_is_empty && !rsp_has_byte && (rsp_out_byte == '0))

endmodule

bind variable_record_stack_core vrs_checker u_vrs_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_out_byte   (rsp.out_byte),
    .rsp_has_byte   (rsp.has_byte),
    .rsp_end_of_run (rsp.end_of_run),
    .rsp_status     (rsp.status),
    .rsp_is_empty   (rsp.is_empty)
);

`default_nettype wire
